// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed (same-cycle implication)");
// next-cycle implication
`define ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed (next-cycle implication)");
`else
`define ASSERT_IMPL(label, clock, reset_n, ante, cons)
`define ASSERT_NEXT(label, clock, reset_n, ante, cons)
`endif
`endif

// ===== src/rcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmf_pkg
// Shared types and constants of the RGB cross median filter.
// ----------------------------------------------------------------------------
package rcmf_pkg;

    localparam int RCMF_MAX_WIDTH  = 4096;
    localparam int RCMF_MAX_HEIGHT = 4096;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_PTS   = 5;            // center plus four neighbors
    localparam int NUM_NB    = NUM_PTS - 1;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int PEND_W    = 3;            // up to three results per pixel

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [COORD_W-1:0] coord_t;

    // stored layout: red in the low byte, apply on top
    typedef struct packed {
        logic                   apply;
        chan_t [NUM_CH-1:0]     rgb;
    } pixel_t;

    typedef struct packed {
        chan_t in_red;
        chan_t in_green;
        chan_t in_blue;
        logic  in_apply;
    } in_word_t;

    typedef struct packed {
        coord_t out_row;
        coord_t out_col;
        chan_t  out_red;
        chan_t  out_green;
        chan_t  out_blue;
        logic   frame_done;
    } out_word_t;

    typedef struct packed {
        logic r_gt0;
        logic r_gt1;
        logic c_gt0;
        logic c_gt1;
        logic has_right;
        logic last_row;
        logic last_col;
    } flags_t;

    // neighborhood held for the pixel in the working stage
    typedef struct packed {
        pixel_t pix;    // current pixel (r,c)
        pixel_t up;     // (r-2,c)
        pixel_t pl;     // (r-1,c-1)
        pixel_t pm;     // (r-1,c)
        pixel_t pr;     // (r-1,c+1)
        pixel_t cl1;    // (r,c-1)
        pixel_t cl2;    // (r,c-2)
        coord_t row;
        coord_t col;
        flags_t flags;
    } win_t;

    typedef enum logic [1:0] {
        RES_UPPER,      // (r-1,c)
        RES_LEFT,       // (r,c-1), last row only
        RES_LAST        // (r,c), last pixel of the frame
    } res_kind_t;

    typedef struct packed {
        pixel_t                center;
        pixel_t [NUM_NB-1:0]   nb;
        logic   [NUM_NB-1:0]   nb_vld;
        coord_t                row;
        coord_t                col;
        logic                  done;
    } op_t;

endpackage

// ===== src/rcmf_stream_if.sv =====
// ----------------------------------------------------------------------------
// rcmf_stream_if
// Valid/ready stream channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface rcmf_stream_if #(
    parameter type word_t = logic
) ();

    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);

endinterface

// ===== src/rcmf_ram.sv =====
// ----------------------------------------------------------------------------
// rcmf_ram
// Simple dual-port RAM: one write port, one registered read port, read-first.
// ----------------------------------------------------------------------------
module rcmf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rcmf_median.sv =====
// ----------------------------------------------------------------------------
// rcmf_median
// Median of up to five 8-bit values; mean of the middle pair on even counts.
// ----------------------------------------------------------------------------
module rcmf_median
    import rcmf_pkg::*;
(
    input  chan_t [NUM_PTS-1:0] vals,
    input  logic  [NUM_PTS-1:0] vld,     // vld[0] must be set
    output chan_t               med
);

    localparam int RANK_W = $clog2(NUM_PTS + 1);

    logic [RANK_W-1:0] rank [NUM_PTS];
    logic [RANK_W-1:0] cnt;
    logic [RANK_W-1:0] lo_rank;
    logic [RANK_W-1:0] hi_rank;
    chan_t             lo_val;
    chan_t             hi_val;
    logic [CH_W:0]     sum;

    // rank = number of valid values sorting below; equal values break by index
    always_comb
    begin
        cnt     = RANK_W'($countones(vld));
        lo_rank = (cnt - RANK_W'(1)) >> 1;
        hi_rank = cnt >> 1;
        lo_val  = '0;
        hi_val  = '0;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < NUM_PTS; j++)
            begin
                if (j != i && vld[j] &&
                    (vals[j] < vals[i] || (vals[j] == vals[i] && j < i)))
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        for (int i = 0; i < NUM_PTS; i++)
        begin
            if (vld[i] && rank[i] == lo_rank)
            begin
                lo_val = vals[i];
            end
            if (vld[i] && rank[i] == hi_rank)
            begin
                hi_val = vals[i];
            end
        end
        sum = {1'b0, lo_val} + {1'b0, hi_val};
        med = sum[CH_W:1];
    end

endmodule

// ===== src/rcmf_select.sv =====
// ----------------------------------------------------------------------------
// rcmf_select
// Picks center, neighbors and coordinates of one result from the window.
// ----------------------------------------------------------------------------
module rcmf_select
    import rcmf_pkg::*;
(
    input  win_t      win,
    input  res_kind_t kind,
    output op_t       op
);

    always_comb
    begin
        op = '0;
        unique case (kind)
            RES_UPPER:
            begin
                op.center    = win.pm;
                op.nb[0]     = win.up;
                op.nb[1]     = win.pix;
                op.nb[2]     = win.pl;
                op.nb[3]     = win.pr;
                op.nb_vld[0] = win.flags.r_gt1;
                op.nb_vld[1] = 1'b1;
                op.nb_vld[2] = win.flags.c_gt0;
                op.nb_vld[3] = win.flags.has_right;
                op.row       = win.row - coord_t'(1);
                op.col       = win.col;
            end
            RES_LEFT:
            begin
                op.center    = win.cl1;
                op.nb[0]     = win.pl;
                op.nb[1]     = win.cl2;
                op.nb[2]     = win.pix;
                op.nb_vld[0] = win.flags.r_gt0;
                op.nb_vld[1] = win.flags.c_gt1;
                op.nb_vld[2] = 1'b1;
                op.row       = win.row;
                op.col       = win.col - coord_t'(1);
            end
            RES_LAST:
            begin
                op.center    = win.pix;
                op.nb[0]     = win.pm;
                op.nb[1]     = win.cl1;
                op.nb_vld[0] = win.flags.r_gt0;
                op.nb_vld[1] = win.flags.c_gt0;
                op.row       = win.row;
                op.col       = win.col;
                op.done      = 1'b1;
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

endmodule

// ===== src/rgb_cross_median_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_cross_median_filter
// Plus-shaped 5-point median filter over an RGB raster stream.
//
// Pixels enter in raster order, one word per cycle while ready is high. For a
// pixel with apply set, each channel becomes the median of the pixel and its
// in-frame up, down, left and right neighbors (original values; the mean of the
// middle pair, rounded down, when the count is even); other pixels pass
// unchanged. Results leave one row behind the input: the pixel at (r,c)
// releases the result for (r-1,c). In the last row each pixel past column 0
// also releases (r,c-1), and the final pixel releases itself with frame_done
// set. Throughput is one pixel per cycle wherever a pixel yields at most one
// result and the output is not stalled; a last-row pixel with two or three
// results holds the input until its extra results have left, since all results
// go through one median unit and one output register. Input reaches the output
// through the working-stage register, then the output register. Two rows live
// in two banks of MAX_WIDTH x 25-bit RAM, one bank per row parity; both banks
// are read once per accepted word; the bank of the current row is also written.
// Writing frame_width or frame_height (only while idle) restarts the frame at
// (0,0); a value of 0 counts as 1, larger ones are capped at MAX_WIDTH and 4096.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_cross_median_filter
    import rcmf_pkg::*;
#(
    parameter int MAX_WIDTH = RCMF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rcmf_stream_if.sink          pixel,
    rcmf_stream_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);        // column counter / RAM address
    localparam int FW_W = $clog2(MAX_WIDTH + 1);    // frame width register

    // bit positions of the pending-result mask, in emission order
    localparam int P_UPPER = 0;
    localparam int P_LEFT  = 1;
    localparam int P_LAST  = 2;

    // ---------------- frame geometry and raster counters ----------------
    logic [FW_W-1:0]    width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [FW_W-1:0]    col_inc;
    logic [CFG_W-1:0]   row_inc;
    flags_t             flags_now;
    logic               accept;
    pixel_t             pix_in;

    assign accept = pixel.valid && pixel.ready;

    assign pix_in.apply = pixel.word.in_apply;
    assign pix_in.rgb   = {pixel.word.in_blue, pixel.word.in_green, pixel.word.in_red};

    assign col_inc = FW_W'(col_reg) + FW_W'(1);
    assign row_inc = CFG_W'(row_reg) + CFG_W'(1);

    always_comb
    begin
        flags_now.r_gt0     = (row_reg != '0);
        flags_now.r_gt1     = (row_reg > COORD_W'(1));
        flags_now.c_gt0     = (col_reg != '0);
        flags_now.c_gt1     = (col_reg > CW'(1));
        flags_now.has_right = (col_inc < width_reg);
        flags_now.last_row  = (row_inc >= height_reg);
        flags_now.last_col  = (col_inc >= width_reg);
    end

    // register writes: clamp to the legal range
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_next = FW_W'(1);
                    else if (32'(cfg_data) > MAX_WIDTH)
                        width_next = FW_W'(MAX_WIDTH);
                    else
                        width_next = FW_W'(cfg_data);
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_next = CFG_W'(1);
                    else if (32'(cfg_data) > RCMF_MAX_HEIGHT)
                        height_next = CFG_W'(RCMF_MAX_HEIGHT);
                    else
                        height_next = cfg_data;
                end
            endcase
        end
    end

    // raster position; any register write restarts the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (flags_now.last_col)
            begin
                col_next = '0;
                row_next = flags_now.last_row ? '0 : row_inc[COORD_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // ---------------- line store: one bank per row parity ----------------
    // The current-parity bank is read at c (row r-2) and written at c in the
    // same edge; read-first gives the old row. The other bank is read at c+1.
    pixel_t bank_rd [2];

    for (genvar k = 0; k < 2; k++)
    begin : g_bank
        logic          own;
        logic [CW-1:0] raddr;

        assign own   = (row_reg[0] == 1'(k));
        assign raddr = own ? col_reg : col_inc[CW-1:0];

        rcmf_ram #(
            .WIDTH ($bits(pixel_t)),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (accept && own),
            .waddr (col_reg),
            .wdata (pix_in),
            .re    (accept),
            .raddr (raddr),
            .rdata (bank_rd[k])
        );
    end

    // ---------------- working stage ----------------
    pixel_t s1_pix_reg, s1_cl1_reg, s1_cl2_reg;
    pixel_t s1_pl_reg, s1_pm_reg;
    pixel_t row_first_reg;      // column 0 of the latest row, for the next row
    coord_t s1_row_reg, s1_col_reg;
    logic   s1_par_reg;
    flags_t s1_flags_reg;
    pixel_t s1_up, s1_pr;

    assign s1_up = s1_par_reg ? bank_rd[1] : bank_rd[0];
    assign s1_pr = s1_par_reg ? bank_rd[0] : bank_rd[1];

    // The upper-row window slides: the c+1 read of the previous pixel is this
    // pixel's (r-1,c). Column 0 has no earlier read, so it comes from row_first.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_in;
            s1_cl1_reg   <= s1_pix_reg;
            s1_cl2_reg   <= s1_cl1_reg;
            s1_pm_reg    <= flags_now.c_gt0 ? s1_pr : row_first_reg;
            s1_pl_reg    <= s1_pm_reg;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= COORD_W'(col_reg);
            s1_par_reg   <= row_reg[0];
            s1_flags_reg <= flags_now;
            if (!flags_now.c_gt0)
            begin
                row_first_reg <= pix_in;
            end
        end
    end

    // pending results of the working-stage pixel, lowest bit goes first
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PEND_W-1:0] pend_low, pend_left, pend_new;
    logic              load_out, emit;
    res_kind_t         kind;

    assign pend_low  = pend_reg & (~pend_reg + PEND_W'(1));
    assign load_out  = !result.valid || result.ready;
    assign emit      = (pend_reg != '0) && load_out;
    assign pend_left = emit ? (pend_reg & ~pend_low) : pend_reg;

    // next word is taken once the last pending result leaves this cycle
    assign pixel.ready = (pend_left == '0);

    always_comb
    begin
        pend_new          = '0;
        pend_new[P_UPPER] = flags_now.r_gt0;
        pend_new[P_LEFT]  = flags_now.last_row && flags_now.c_gt0;
        pend_new[P_LAST]  = flags_now.last_row && flags_now.last_col;
        pend_next         = accept ? pend_new : pend_left;
    end

    always_comb
    begin
        if (pend_low[P_UPPER])
            kind = RES_UPPER;
        else if (pend_low[P_LEFT])
            kind = RES_LEFT;
        else
            kind = RES_LAST;
    end

    win_t win;
    op_t  op;

    always_comb
    begin
        win.pix   = s1_pix_reg;
        win.up    = s1_up;
        win.pl    = s1_pl_reg;
        win.pm    = s1_pm_reg;
        win.pr    = s1_pr;
        win.cl1   = s1_cl1_reg;
        win.cl2   = s1_cl2_reg;
        win.row   = s1_row_reg;
        win.col   = s1_col_reg;
        win.flags = s1_flags_reg;
    end

    rcmf_select u_select (
        .win  (win),
        .kind (kind),
        .op   (op)
    );

    // one median per channel
    chan_t [NUM_CH-1:0] filt;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_ch
        chan_t [NUM_PTS-1:0] vals;
        chan_t               med;

        always_comb
        begin
            vals[0] = op.center.rgb[ch];
            for (int k = 0; k < NUM_NB; k++)
            begin
                vals[k + 1] = op.nb[k].rgb[ch];
            end
        end

        rcmf_median u_median (
            .vals (vals),
            .vld  ({op.nb_vld, 1'b1}),
            .med  (med)
        );

        assign filt[ch] = op.center.apply ? med : op.center.rgb[ch];
    end

    // ---------------- output register ----------------
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t res_word;

    always_comb
    begin
        res_word.out_row    = op.row;
        res_word.out_col    = op.col;
        res_word.out_red    = filt[0];
        res_word.out_green  = filt[1];
        res_word.out_blue   = filt[2];
        res_word.frame_done = op.done;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= res_word;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.word  = out_word_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= FW_W'(1);
            height_reg    <= CFG_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            if (load_out)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_one_pending_at_accept, clk, rst_n, accept, $countones(pend_reg) <= 1)
    `ASSERT_NEXT(a_upper_result_queued, clk, rst_n, accept && flags_now.r_gt0, pend_reg[P_UPPER])
    `ASSERT_IMPL(a_col_in_frame, clk, rst_n, 1'b1, col_inc <= width_reg)
    `ASSERT_IMPL(a_done_at_corner, clk, rst_n, result.valid && result.word.frame_done, result.word.out_row == COORD_W'(height_reg - CFG_W'(1)) && result.word.out_col == COORD_W'(width_reg - FW_W'(1)))

endmodule
